// ===== rtl/core/vntg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vntg_pkg
// Shared types and constants of the value noise texel generator.
// ----------------------------------------------------------------------------
package vntg_pkg;

	localparam int TEX_SIZE_DEF = 256;
	localparam int VOL_SIZE_DEF = 32;

	localparam int COORD_W  = 8;
	localparam int SLICE_W  = 5;
	localparam int HX_W     = 12;
	localparam int HB_W     = 4;
	localparam int LG_W     = 4;
	localparam int BYTE_W   = 8;
	localparam int HASH_W   = 24;
	localparam int WEIGHT_W = 25;
	localparam int NUM_BANDS = 4;
	localparam int PIPE_DEPTH = 10;

	localparam logic [LG_W-1:0] MAX_LOG2 = LG_W'(8);
	localparam logic [HB_W-1:0] WEAR_BAND_BASE = HB_W'(8);

	localparam logic [31:0] SEED_MUL_X = 32'h9E3779B1;
	localparam logic [31:0] SEED_MUL_Y = 32'h85EBCA77;
	localparam logic [31:0] SEED_MUL_B = 32'hC2B2AE3D;
	localparam logic [31:0] MIX_MUL_1  = 32'hED5AD4BB;
	localparam logic [31:0] MIX_MUL_2  = 32'hAC4C1B51;

	localparam logic [HASH_W-1:0] MAX24 = 24'hFFFFFF;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_BAND0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAND1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BAND2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BAND3 = 2'd3;

	localparam logic [LG_W-1:0] BAND0_RESET = 4'd2;
	localparam logic [LG_W-1:0] BAND1_RESET = 4'd4;
	localparam logic [LG_W-1:0] BAND2_RESET = 4'd6;
	localparam logic [LG_W-1:0] BAND3_RESET = 4'd7;

	typedef struct packed {
		logic               op;
		logic [COORD_W-1:0] x_coord;
		logic [COORD_W-1:0] y_coord;
		logic [SLICE_W-1:0] z_coord;
	} texel_in_t;

	typedef struct packed {
		logic [BYTE_W-1:0] chan_red;
		logic [BYTE_W-1:0] chan_green;
		logic [BYTE_W-1:0] chan_blue;
		logic [BYTE_W-1:0] chan_alpha;
	} texel_out_t;

endpackage

// ===== rtl/core/vntg_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vntg_hash
// Four-stage pipelined 32-bit integer mix hash; returns the top 24 bits.
// ----------------------------------------------------------------------------
module vntg_hash (
	input  logic                      clk,
	input  logic                      en,
	input  logic [vntg_pkg::HX_W-1:0] hx,
	input  logic [vntg_pkg::COORD_W-1:0] hy,
	input  logic [vntg_pkg::HB_W-1:0] hb,
	output logic [vntg_pkg::HASH_W-1:0] h
);
	import vntg_pkg::*;

	logic [31:0] seed_s2, mix1_s3, mix2_s4;
	logic [HASH_W-1:0] h_s5;
	logic [31:0] v1, v2, v3;

	assign v1 = seed_s2 ^ (seed_s2 >> 17);
	assign v2 = mix1_s3 ^ (mix1_s3 >> 11);
	assign v3 = mix2_s4 ^ (mix2_s4 >> 13);

	always_ff @(posedge clk) begin
		if (en) begin
			seed_s2 <= 32'(32'(hx) * SEED_MUL_X) + 32'(32'(hy) * SEED_MUL_Y)
			         + 32'(32'(hb) * SEED_MUL_B);
			mix1_s3 <= 32'(v1 * MIX_MUL_1);
			mix2_s4 <= 32'(v2 * MIX_MUL_2);
			h_s5    <= v3[31:8];
		end
	end

	assign h = h_s5;
endmodule

// ===== rtl/core/vntg_band.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vntg_band
// One noise channel: lattice setup, corner hashes, smoothstep weights,
// bilinear blend and scaling to a byte, ten register stages deep.
// ----------------------------------------------------------------------------
module vntg_band #(
	parameter int TEX_SIZE = vntg_pkg::TEX_SIZE_DEF,
	parameter int VOL_SIZE = vntg_pkg::VOL_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  vntg_pkg::texel_in_t          texel,
	input  logic [vntg_pkg::LG_W-1:0]    cells_log2,
	input  logic [1:0]                   band_id,
	output logic [vntg_pkg::BYTE_W-1:0]  chan
);
	import vntg_pkg::*;

	// TEX_SIZE is a power of two, so the cell grid divides by shifting.
	localparam int K     = $clog2(TEX_SIZE) + 1;
	localparam int D     = 2 * TEX_SIZE;
	localparam int NUM_W = 3 * K + 2;
	localparam logic [K+1:0] THREE_D = (K+2)'(3 * D);
	localparam int PX_W  = COORD_W + 1 + 8;

	// Stage 1: lattice corners and cell fractions.
	logic [LG_W-1:0]    lg;
	logic [PX_W-1:0]    px, py;
	logic [8:0]         mask;
	logic [COORD_W-1:0] x0, x1, y0, y1;
	logic [HX_W-1:0]    wear_x;

	logic [HX_W-1:0]    hx0_s1, hx1_s1;
	logic [COORD_W-1:0] hy0_s1, hy1_s1;
	logic [HB_W-1:0]    hb_s1;
	logic [K-1:0]       rx_s1, ry_s1;

	always_comb begin
		lg     = (cells_log2 > MAX_LOG2) ? MAX_LOG2 : cells_log2;
		mask   = 9'((10'd1 << lg) - 10'd1);
		px     = PX_W'({texel.x_coord, 1'b1}) << lg;
		py     = PX_W'({texel.y_coord, 1'b1}) << lg;
		x0     = COORD_W'((px >> K) & PX_W'(mask));
		y0     = COORD_W'((py >> K) & PX_W'(mask));
		x1     = COORD_W'((9'(x0) + 9'd1) & mask);
		y1     = COORD_W'((9'(y0) + 9'd1) & mask);
		wear_x = HX_W'(texel.x_coord) + HX_W'(texel.z_coord * VOL_SIZE);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (texel.op) begin
				// Raw hash: corner zero carries the voxel, zero weights pass it through.
				hx0_s1 <= wear_x;
				hx1_s1 <= wear_x;
				hy0_s1 <= texel.y_coord;
				hy1_s1 <= texel.y_coord;
				hb_s1  <= WEAR_BAND_BASE + HB_W'(band_id);
				rx_s1  <= '0;
				ry_s1  <= '0;
			end else begin
				hx0_s1 <= HX_W'(x0);
				hx1_s1 <= HX_W'(x1);
				hy0_s1 <= y0;
				hy1_s1 <= y1;
				hb_s1  <= HB_W'(band_id);
				rx_s1  <= px[K-1:0];
				ry_s1  <= py[K-1:0];
			end
		end
	end

	// Stages 2 to 5: corner hashes.
	logic [HASH_W-1:0] ha, hbb, hc, he;

	vntg_hash u_hash_a (.clk, .en, .hx(hx0_s1), .hy(hy0_s1), .hb(hb_s1), .h(ha));
	vntg_hash u_hash_b (.clk, .en, .hx(hx1_s1), .hy(hy0_s1), .hb(hb_s1), .h(hbb));
	vntg_hash u_hash_c (.clk, .en, .hx(hx0_s1), .hy(hy1_s1), .hb(hb_s1), .h(hc));
	vntg_hash u_hash_e (.clk, .en, .hx(hx1_s1), .hy(hy1_s1), .hb(hb_s1), .h(he));

	// Stages 2 to 5: smoothstep weights, s = r^2 (3D - 2r) 2^24 / D^3.
	logic [2*K-1:0]      rxsq_s2, rysq_s2;
	logic [K+1:0]        tx_s2, ty_s2;
	logic [NUM_W-1:0]    nx_s3, ny_s3;
	logic [WEIGHT_W-1:0] sx_s4, sy_s4, sx_s5, sy_s5;
	logic [NUM_W+23:0]   nx_wide, ny_wide;

	assign nx_wide = {nx_s3, 24'd0};
	assign ny_wide = {ny_s3, 24'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			rxsq_s2 <= (2*K)'(rx_s1 * rx_s1);
			rysq_s2 <= (2*K)'(ry_s1 * ry_s1);
			tx_s2   <= THREE_D - (K+2)'({rx_s1, 1'b0});
			ty_s2   <= THREE_D - (K+2)'({ry_s1, 1'b0});
			nx_s3   <= NUM_W'(rxsq_s2 * tx_s2);
			ny_s3   <= NUM_W'(rysq_s2 * ty_s2);
			sx_s4   <= WEIGHT_W'(nx_wide >> (3 * K));
			sy_s4   <= WEIGHT_W'(ny_wide >> (3 * K));
			sx_s5   <= sx_s4;
			sy_s5   <= sy_s4;
		end
	end

	// Stages 6 to 9: bilinear blend as a + (b - a) s.
	logic signed [HASH_W:0]    dtop, dbot, dy;
	logic signed [50:0]        ptop_s6, pbot_s6, py_s8;
	logic [HASH_W-1:0]         a_s6, c_s6, top_s7, top_s8;
	logic [WEIGHT_W-1:0]       sy_s6, sy_s7;
	logic signed [HASH_W:0]    dy_s7;
	logic signed [51:0]        sum_top, sum_bot, sum_y;
	logic [HASH_W-1:0]         top, bot, val;
	logic [32:0]               n_s9;

	assign dtop    = $signed({1'b0, hbb}) - $signed({1'b0, ha});
	assign dbot    = $signed({1'b0, he}) - $signed({1'b0, hc});
	assign sum_top = $signed({1'b0, a_s6, 24'd0}) + ptop_s6;
	assign sum_bot = $signed({1'b0, c_s6, 24'd0}) + pbot_s6;
	assign top     = sum_top[47:24];
	assign bot     = sum_bot[47:24];
	assign dy      = $signed({1'b0, bot}) - $signed({1'b0, top});
	assign sum_y   = $signed({1'b0, top_s8, 24'd0}) + py_s8;
	assign val     = sum_y[47:24];

	always_ff @(posedge clk) begin
		if (en) begin
			ptop_s6 <= dtop * $signed({1'b0, sx_s5});
			pbot_s6 <= dbot * $signed({1'b0, sx_s5});
			a_s6    <= ha;
			c_s6    <= hc;
			sy_s6   <= sy_s5;
			top_s7  <= top;
			dy_s7   <= dy;
			sy_s7   <= sy_s6;
			py_s8   <= dy_s7 * $signed({1'b0, sy_s7});
			top_s8  <= top_s7;
			n_s9    <= 33'(33'(val) * 33'd510) + 33'(MAX24);
		end
	end

	// Stage 10: n / (2^25 - 2). The shift estimate is low by at most one.
	logic [BYTE_W-1:0] q0;
	logic [25:0]       rem;
	logic [BYTE_W-1:0] chan_s10;

	assign q0  = n_s9[32:25];
	assign rem = {1'b0, n_s9[24:0]} + {17'd0, q0, 1'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			chan_s10 <= (rem >= 26'd33554430) ? q0 + 8'd1 : q0;
		end
	end

	assign chan = chan_s10;
endmodule

// ===== rtl/core/value_noise_texel_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_noise_texel_generator_core
// Four-channel value noise and raw hash texel generator.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, in_data) takes one beat per texel:
// an op bit, the texel column and row, and a slice for wear mode. The output
// channel (out_valid, out_stall, out_data) returns one RGBA beat per input
// beat, in order. Op zero gives tileable smoothstep value noise per channel,
// op one gives the raw hash of each voxel.
// One beat is accepted every cycle unless a finished output beat is stalled:
// each channel is a ten-stage pipeline whose stages are lattice setup, four
// hash stages in parallel with the smoothstep weight multipliers, the blend
// stages with their multipliers and adds, and the byte scaling.
// When the receiver stalls a valid output beat, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears the stage valid bits and loads the four band registers with
// their defaults. The user writes them through cfg_we, cfg_index, cfg_data
// only while the pipeline is empty; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module value_noise_texel_generator_core #(
	parameter int TEX_SIZE = vntg_pkg::TEX_SIZE_DEF,
	parameter int VOL_SIZE = vntg_pkg::VOL_SIZE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  vntg_pkg::texel_in_t             in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output vntg_pkg::texel_out_t            out_data,
	input  logic                            cfg_we,
	input  logic [vntg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vntg_pkg::LG_W-1:0]       cfg_data
);
	import vntg_pkg::*;

	logic [LG_W-1:0] band_lg_q [NUM_BANDS];

	// Band registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_lg_q[0] <= BAND0_RESET;
			band_lg_q[1] <= BAND1_RESET;
			band_lg_q[2] <= BAND2_RESET;
			band_lg_q[3] <= BAND3_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BAND0: band_lg_q[0] <= cfg_data;
				REG_BAND1: band_lg_q[1] <= cfg_data;
				REG_BAND2: band_lg_q[2] <= cfg_data;
				REG_BAND3: band_lg_q[3] <= cfg_data;
				default:   band_lg_q[0] <= band_lg_q[0];
			endcase
		end
	end

	// The pipeline advances unless a finished beat is being held back.
	logic                  advance;
	logic [PIPE_DEPTH-1:0] stage_valid_q;

	assign advance   = !(stage_valid_q[PIPE_DEPTH-1] && out_stall);
	assign in_stall  = !advance;
	assign out_valid = stage_valid_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else if (advance) begin
			stage_valid_q <= {stage_valid_q[PIPE_DEPTH-2:0], in_valid};
		end
	end

	logic [BYTE_W-1:0] chan [NUM_BANDS];

	for (genvar b = 0; b < NUM_BANDS; b++) begin : g_band
		vntg_band #(
			.TEX_SIZE(TEX_SIZE),
			.VOL_SIZE(VOL_SIZE)
		) u_band (
			.clk,
			.en        (advance),
			.texel     (in_data),
			.cells_log2(band_lg_q[b]),
			.band_id   (2'(b)),
			.chan      (chan[b])
		);
	end

	assign out_data.chan_red   = chan[0];
	assign out_data.chan_green = chan[1];
	assign out_data.chan_blue  = chan[2];
	assign out_data.chan_alpha = chan[3];
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the value noise texel generator core.
// ----------------------------------------------------------------------------
// The bench drives texel beats through the valid/stall input channel, then
// checks every output beat against an internal noise predictor, in order. It
// starts with a short directed table and moves on to random beats. The band
// registers are set to several values between phases, the extremes included.
// ----------------------------------------------------------------------------
module testbench;
	import vntg_pkg::*;

	localparam int    TEX = 256;
	localparam int    VOL = 32;
	localparam int    LATENCY = PIPE_DEPTH;
	localparam int    RANDOM_BEATS = 1200;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	texel_in_t  in_data;
	logic       out_valid;
	logic       out_stall;
	texel_out_t out_data;
	logic       cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LG_W-1:0]      cfg_data;

	// Band register copy held by the predictor.
	logic [LG_W-1:0] band_lg [NUM_BANDS];

	// Expected output beats, oldest first.
	texel_out_t pending_texels[$];
	int         mismatch_count;
	bit         quiet_phase;

	// One row of the directed table. A row with want_known set carries its
	// expected beat; every other row is checked through the predictor.
	typedef struct {
		texel_in_t  beat;
		bit         want_known;
		texel_out_t want;
	} texel_row_t;

	value_noise_texel_generator_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// The 32-bit integer mix hash; the top 24 bits of the mixed word.
	function automatic logic [23:0] lattice_hash(logic [63:0] hx, logic [63:0] hy,
			logic [63:0] hb);
		logic [31:0] v;
		v = 32'(hx * 64'h9E3779B1 + hy * 64'h85EBCA77 + hb * 64'hC2B2AE3D);
		v = v ^ (v >> 17);
		v = v * 32'hED5AD4BB;
		v = v ^ (v >> 11);
		v = v * 32'hAC4C1B51;
		v = v ^ (v >> 13);
		return v[31:8];
	endfunction

	function automatic logic [7:0] hash_to_byte(logic [63:0] h);
		return 8'((2 * 255 * h + 64'hFFFFFF) / (2 * 64'hFFFFFF));
	endfunction

	function automatic logic [63:0] lerp24(logic [63:0] a, logic [63:0] b, logic [63:0] s);
		return (a * ((64'd1 << 24) - s) + b * s) >> 24;
	endfunction

	function automatic logic [63:0] smooth_frac(logic [63:0] r, logic [63:0] d);
		logic [63:0] num;
		num = r * r * (3 * d - 2 * r);
		return (num << 24) / (d * d * d);
	endfunction

	// Tileable value noise of one band at one texel.
	function automatic logic [63:0] band_noise(logic [63:0] x, logic [63:0] y,
			logic [63:0] lg, logic [63:0] band);
		logic [63:0] d, cells, mask, px, py, x0, y0, x1, y1, sx, sy, top, bot;
		d = 2 * TEX;
		cells = 64'd1 << lg;
		mask = cells - 1;
		px = (2 * x + 1) * cells;
		py = (2 * y + 1) * cells;
		x0 = (px / d) & mask;
		y0 = (py / d) & mask;
		x1 = (x0 + 1) & mask;
		y1 = (y0 + 1) & mask;
		sx = smooth_frac(px % d, d);
		sy = smooth_frac(py % d, d);
		top = lerp24(lattice_hash(x0, y0, band), lattice_hash(x1, y0, band), sx);
		bot = lerp24(lattice_hash(x0, y1, band), lattice_hash(x1, y1, band), sx);
		return lerp24(top, bot, sy);
	endfunction

	function automatic texel_out_t predict_texel(texel_in_t t);
		logic [7:0]  ch [NUM_BANDS];
		logic [63:0] lg;
		logic [63:0] h;
		for (int b = 0; b < NUM_BANDS; b++) begin
			if (t.op) begin
				h = lattice_hash(64'(t.x_coord) + 64'(t.z_coord) * VOL, 64'(t.y_coord),
					64'(b) + 64'(WEAR_BAND_BASE));
			end else begin
				// Register values above eight saturate to eight cells log2.
				lg = (band_lg[b] > MAX_LOG2) ? 64'(MAX_LOG2) : 64'(band_lg[b]);
				h = band_noise(64'(t.x_coord), 64'(t.y_coord), lg, 64'(b));
			end
			ch[b] = hash_to_byte(h);
		end
		return '{chan_red: ch[0], chan_green: ch[1], chan_blue: ch[2], chan_alpha: ch[3]};
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// Output side: random stall bursts, and a check of every accepted beat.
	initial begin
		int burst;
		out_stall = 1'b0;
		burst = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_texels.size() == 0) begin
					report_mismatch("unexpected beat", out_data, 0);
				end else begin
					texel_out_t want;
					want = pending_texels.pop_front();
					if (out_data.chan_red !== want.chan_red)
						report_mismatch("chan_red", out_data.chan_red, want.chan_red);
					if (out_data.chan_green !== want.chan_green)
						report_mismatch("chan_green", out_data.chan_green, want.chan_green);
					if (out_data.chan_blue !== want.chan_blue)
						report_mismatch("chan_blue", out_data.chan_blue, want.chan_blue);
					if (out_data.chan_alpha !== want.chan_alpha)
						report_mismatch("chan_alpha", out_data.chan_alpha, want.chan_alpha);
				end
			end
			// Random stall bursts, switched off near the end.
			if (burst > 0) begin
				burst--;
				out_stall <= 1'b1;
			end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Sends one beat, sometimes with a random idle burst ahead of it. The expected
	// beat is queued when the handshake completes. Valid stays high so that
	// the next beat can follow at once; stop_sending drops it.
	task automatic send_texel(texel_in_t t, texel_out_t want);
		if (!quiet_phase && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= t;
		do @(posedge clk); while (in_stall);
		pending_texels.push_back(want);
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
	endtask

	// Waits for the pipeline to drain so that the band registers may change.
	task automatic drain_pipeline();
		stop_sending();
		while (pending_texels.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_band(logic [CFG_IDX_W-1:0] idx, logic [LG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		band_lg[idx] = val;
	endtask

	task automatic set_bands(logic [LG_W-1:0] v0, logic [LG_W-1:0] v1,
			logic [LG_W-1:0] v2, logic [LG_W-1:0] v3);
		drain_pipeline();
		write_band(REG_BAND0, v0);
		write_band(REG_BAND1, v1);
		write_band(REG_BAND2, v2);
		write_band(REG_BAND3, v3);
		cfg_we <= 1'b0;
	endtask

	function automatic texel_in_t random_texel();
		texel_in_t t;
		t.op = 1'($urandom_range(0, 1));
		t.x_coord = 8'($urandom);
		t.y_coord = 8'($urandom);
		t.z_coord = 5'($urandom);
		// Wear mode mostly stays inside the volume, with the odd stray.
		if (t.op && $urandom_range(0, 3) != 0) begin
			t.x_coord = 8'($urandom_range(0, VOL - 1));
			t.y_coord = 8'($urandom_range(0, VOL - 1));
		end
		return t;
	endfunction

	task automatic run_random(int count);
		texel_in_t t;
		for (int i = 0; i < count; i++) begin
			t = random_texel();
			send_texel(t, predict_texel(t));
		end
	endtask

	initial begin
		texel_row_t rows[$];
		texel_row_t row;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = REG_BAND0;
		cfg_data = '0;
		quiet_phase = 1'b0;
		mismatch_count = 0;
		band_lg[0] = BAND0_RESET;
		band_lg[1] = BAND1_RESET;
		band_lg[2] = BAND2_RESET;
		band_lg[3] = BAND3_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table with the reset band sizes: coordinate corners in both
		// modes, detail beats carrying a nonzero slice that must be ignored,
		// and wear coordinates beyond the volume.
		row.want_known = 1'b0;
		row.want = '0;
		row.beat = '{op: 1'b0, x_coord: 8'd0,   y_coord: 8'd0,   z_coord: 5'd0};  rows.push_back(row);
		row.beat = '{op: 1'b0, x_coord: 8'd255, y_coord: 8'd255, z_coord: 5'd31}; rows.push_back(row);
		row.beat = '{op: 1'b0, x_coord: 8'd255, y_coord: 8'd0,   z_coord: 5'd0};  rows.push_back(row);
		row.beat = '{op: 1'b0, x_coord: 8'd0,   y_coord: 8'd255, z_coord: 5'd17}; rows.push_back(row);
		row.beat = '{op: 1'b0, x_coord: 8'd127, y_coord: 8'd128, z_coord: 5'd0};  rows.push_back(row);
		row.beat = '{op: 1'b0, x_coord: 8'd170, y_coord: 8'd85,  z_coord: 5'd10}; rows.push_back(row);
		row.beat = '{op: 1'b1, x_coord: 8'd0,   y_coord: 8'd0,   z_coord: 5'd0};  rows.push_back(row);
		row.beat = '{op: 1'b1, x_coord: 8'd31,  y_coord: 8'd31,  z_coord: 5'd31}; rows.push_back(row);
		row.beat = '{op: 1'b1, x_coord: 8'd255, y_coord: 8'd255, z_coord: 5'd31}; rows.push_back(row);
		row.beat = '{op: 1'b1, x_coord: 8'd128, y_coord: 8'd64,  z_coord: 5'd21}; rows.push_back(row);
		row.beat = '{op: 1'b1, x_coord: 8'd85,  y_coord: 8'd170, z_coord: 5'd10}; rows.push_back(row);
		foreach (rows[i]) begin
			send_texel(rows[i].beat,
				rows[i].want_known ? rows[i].want : predict_texel(rows[i].beat));
		end

		// A single lattice cell has every corner on one hash, so each band
		// gives the byte of its own hash at the origin.
		set_bands(4'd0, 4'd0, 4'd0, 4'd0);
		for (int i = 0; i < 4; i++) begin
			texel_in_t t;
			t = random_texel();
			t.op = 1'b0;
			send_texel(t, predict_texel(t));
		end

		// Largest count, then values above eight that saturate.
		set_bands(4'd8, 4'd8, 4'd8, 4'd8);
		run_random(6);
		set_bands(4'd15, 4'd9, 4'd12, 4'd8);
		run_random(6);

		// Random phases across several band settings.
		set_bands(BAND0_RESET, BAND1_RESET, BAND2_RESET, BAND3_RESET);
		run_random(RANDOM_BEATS / 4);
		// Hold off until the pipeline is empty, then resume.
		stop_sending();
		while (pending_texels.size() != 0) @(posedge clk);
		run_random(RANDOM_BEATS / 4);
		set_bands(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
			4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
		run_random(RANDOM_BEATS / 4);
		set_bands(4'd1, 4'd3, 4'd5, 4'd15);
		run_random(RANDOM_BEATS / 8);
		quiet_phase = 1'b1;
		run_random(RANDOM_BEATS / 8);

		stop_sending();
		while (pending_texels.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("TIMEOUT waiting for output beats");
		$display("end of test: mismatches");
		$finish;
	end

endmodule
